FILE: rtl/core/a2pa_pkg.sv
// ----------------------------------------------------------------------------
// a2pa_pkg
// Shared widths, coefficients and the cell payload for the atan2 angle unit.
// ----------------------------------------------------------------------------
package a2pa_pkg;

    localparam int INPUT_WIDTH     = 16;
    localparam int RATIO_FRAC_BITS = 18;
    localparam int ANGLE_WIDTH     = 16;

    // |num| and den fit in INPUT_WIDTH+1 bits unsigned
    localparam int MAG_WIDTH = INPUT_WIDTH + 2;
    // dividend is |num| << F, plus rounding bits
    localparam int DIVD_WIDTH = MAG_WIDTH + RATIO_FRAC_BITS + 1;
    // quotient bits: |t| <= 2^F
    localparam int QUOT_BITS  = RATIO_FRAC_BITS + 1;
    // one restoring-division step per cell
    localparam int DIV_CELLS  = QUOT_BITS;
    localparam int REM_WIDTH  = MAG_WIDTH + 1;

    // signed fixed-point datapath width for t, t2 and Horner values
    localparam int T_WIDTH    = RATIO_FRAC_BITS + 2;
    localparam int P_WIDTH    = RATIO_FRAC_BITS + 18;
    localparam int PROD_WIDTH = T_WIDTH + P_WIDTH;
    localparam int SUM_WIDTH  = RATIO_FRAC_BITS + 18;

    localparam int COEF_SHIFT = 24 - RATIO_FRAC_BITS;

    localparam logic signed [63:0] C1_Q24 = -64'sd174855283062;
    localparam logic signed [63:0] C3_Q24 =  64'sd56203599069;
    localparam logic signed [63:0] C5_Q24 = -64'sd25594836885;
    localparam logic signed [63:0] C7_Q24 =  64'sd6821774643;

    function automatic logic signed [63:0] coef_round(input logic signed [63:0] c);
        logic [63:0] m;
        begin
            m = (c < 0) ? 64'(-c) : 64'(c);
            if (COEF_SHIFT != 0)
            begin
                m = (m + (64'd1 << (COEF_SHIFT - 1))) >> COEF_SHIFT;
            end
            coef_round = (c < 0) ? -$signed(m) : $signed(m);
        end
    endfunction

    localparam logic signed [P_WIDTH-1:0] C1_F = P_WIDTH'(coef_round(C1_Q24));
    localparam logic signed [P_WIDTH-1:0] C3_F = P_WIDTH'(coef_round(C3_Q24));
    localparam logic signed [P_WIDTH-1:0] C5_F = P_WIDTH'(coef_round(C5_Q24));
    localparam logic signed [P_WIDTH-1:0] C7_F = P_WIDTH'(coef_round(C7_Q24));

    localparam logic [SUM_WIDTH-1:0] OFFS_POS = SUM_WIDTH'(64'd16385 << (RATIO_FRAC_BITS - 1));
    localparam logic [SUM_WIDTH-1:0] OFFS_NEG = SUM_WIDTH'(64'd49153 << (RATIO_FRAC_BITS - 1));

    // payload carried along the divider row
    typedef struct packed {
        logic                  valid;
        logic [REM_WIDTH-1:0]  rem;
        logic [DIVD_WIDTH-1:0] divd;
        logic [MAG_WIDTH-1:0]  den;
        logic [QUOT_BITS-1:0]  quot;
        logic                  num_neg;
        logic                  x_neg;
        logic                  y_neg;
    } div_cell_t;

    // right shift by F, rounded half away from zero
    function automatic logic signed [PROD_WIDTH-1:0] shr_round(
        input logic signed [PROD_WIDTH-1:0] v);
        logic [PROD_WIDTH-1:0] m;
        begin
            m = v[PROD_WIDTH-1] ? PROD_WIDTH'(-v) : PROD_WIDTH'(v);
            m = (m + (PROD_WIDTH'(1) << (RATIO_FRAC_BITS - 1))) >> RATIO_FRAC_BITS;
            shr_round = v[PROD_WIDTH-1] ? -$signed(m) : $signed(m);
        end
    endfunction

endpackage

FILE: rtl/core/a2pa_stream_if.sv
// ----------------------------------------------------------------------------
// a2pa_stream_if
// Valid/ready channel carrying a generic payload.
// ----------------------------------------------------------------------------
interface a2pa_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/core/a2pa_div_cell.sv
// ----------------------------------------------------------------------------
// a2pa_div_cell
// One restoring-division step: shift in a dividend bit, trial subtract.
// ----------------------------------------------------------------------------
module a2pa_div_cell
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  a2pa_pkg::div_cell_t   cell_in,
    output a2pa_pkg::div_cell_t   cell_out
);
    import a2pa_pkg::*;

    div_cell_t              cell_reg;
    div_cell_t              cell_next;
    logic [REM_WIDTH-1:0]   shifted;
    logic [REM_WIDTH:0]     diff;

    always_comb
    begin
        cell_next = cell_in;
        shifted   = {cell_in.rem[REM_WIDTH-2:0], cell_in.divd[DIVD_WIDTH-1]};
        diff      = {1'b0, shifted} - {2'b00, cell_in.den};
        cell_next.divd = {cell_in.divd[DIVD_WIDTH-2:0], 1'b0};
        if (!diff[REM_WIDTH])
        begin
            cell_next.rem  = diff[REM_WIDTH-1:0];
            cell_next.quot = {cell_in.quot[QUOT_BITS-2:0], 1'b1};
        end
        else
        begin
            cell_next.rem  = shifted;
            cell_next.quot = {cell_in.quot[QUOT_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= '0;
        end
        else if (advance)
        begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

`ifndef SYNTHESIS
    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        cell_reg.valid |-> (cell_reg.rem < REM_WIDTH'(cell_reg.den)))
        else $error("remainder not below divisor");
`endif

endmodule

FILE: rtl/core/a2pa_poly.sv
// ----------------------------------------------------------------------------
// a2pa_poly
// Pipelined Horner evaluation of the odd polynomial, offset, clamp and fold.
// ----------------------------------------------------------------------------
module a2pa_poly
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              advance,
    input  logic                              in_valid,
    input  logic signed [a2pa_pkg::T_WIDTH-1:0] t_in,
    input  logic                              x_neg,
    input  logic                              y_neg,
    output logic                              out_valid,
    output logic [a2pa_pkg::ANGLE_WIDTH-1:0]  angle
);
    import a2pa_pkg::*;

    localparam int STAGES = 11;

    typedef struct packed {
        logic                        valid;
        logic signed [T_WIDTH-1:0]   t;
        logic signed [T_WIDTH-1:0]   t2;
        logic signed [P_WIDTH-1:0]   p;
        logic signed [PROD_WIDTH-1:0] prod;
        logic                        x_neg;
        logic                        y_neg;
    } pstage_t;

    pstage_t st_reg [STAGES];
    pstage_t st_next [STAGES];

    logic signed [PROD_WIDTH-1:0] sq;
    logic signed [PROD_WIDTH-1:0] rnd;
    logic [SUM_WIDTH-1:0]         sum;
    logic [ANGLE_WIDTH-1:0]       ang;

    always_comb
    begin
        st_next[0] = '0;
        for (int i = 1; i < STAGES; i++)
        begin
            st_next[i] = st_reg[i-1];
        end
        st_next[0].valid = in_valid;
        st_next[0].t     = t_in;
        st_next[0].x_neg = x_neg;
        st_next[0].y_neg = y_neg;
        sq = PROD_WIDTH'(t_in) * PROD_WIDTH'(t_in);
        st_next[0].prod = sq;
        // t2 rounded, p = c7
        st_next[1].t2 = T_WIDTH'(shr_round(st_reg[0].prod));
        st_next[1].p  = C7_F;
        // three Horner steps: multiply stage then round-add stage
        st_next[2].prod = PROD_WIDTH'(st_reg[1].t2) * PROD_WIDTH'(st_reg[1].p);
        rnd = shr_round(st_reg[2].prod);
        st_next[3].p = C5_F + P_WIDTH'(rnd);
        st_next[4].prod = PROD_WIDTH'(st_reg[3].t2) * PROD_WIDTH'(st_reg[3].p);
        st_next[5].p = C3_F + P_WIDTH'(shr_round(st_reg[4].prod));
        st_next[6].prod = PROD_WIDTH'(st_reg[5].t2) * PROD_WIDTH'(st_reg[5].p);
        st_next[7].p = C1_F + P_WIDTH'(shr_round(st_reg[6].prod));
        st_next[8].prod = PROD_WIDTH'(st_reg[7].t) * PROD_WIDTH'(st_reg[7].p);
        st_next[9].p = P_WIDTH'(shr_round(st_reg[8].prod));
        // offset, clamp and fold
        sum = (st_reg[9].x_neg ? OFFS_NEG : OFFS_POS) + SUM_WIDTH'(st_reg[9].p);
        if (sum[SUM_WIDTH-1])
        begin
            ang = '0;
        end
        else
        begin
            ang = sum[RATIO_FRAC_BITS +: ANGLE_WIDTH];
        end
        if (st_reg[9].y_neg)
        begin
            ang = -ang;
        end
        st_next[10].p = P_WIDTH'(ang);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STAGES; i++)
            begin
                st_reg[i] <= '0;
            end
        end
        else if (advance)
        begin
            for (int i = 0; i < STAGES; i++)
            begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    assign out_valid = st_reg[STAGES-1].valid;
    assign angle     = st_reg[STAGES-1].p[ANGLE_WIDTH-1:0];

`ifndef SYNTHESIS
    a_t2_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg[1].valid |-> !st_reg[1].t2[T_WIDTH-1])
        else $error("t squared negative");
    a_adv_shift: assert property (@(posedge clk) disable iff (!rst_n)
        $past(advance) |-> st_reg[STAGES-1].valid == $past(st_reg[STAGES-2].valid))
        else $error("pipeline valid did not advance");
`endif

endmodule

FILE: rtl/core/atan2_polynomial_angle.sv
// ----------------------------------------------------------------------------
// atan2_polynomial_angle
// 16-bit atan2 angle: pipelined ratio divider row and polynomial pipeline.
// ----------------------------------------------------------------------------
//   channel  dir  payload
//   in_ch    in   sine_value[15:0] s, cosine_value[15:0] s
//   out_ch   out  angle[15:0] u
//
// One request per clock while the output is not stalled; the path is a head register,
// F+1 divider cells and 11 polynomial stages. The row of division cells sets the length.
// The whole pipeline stalls only when the output holds a result not taken.
// Reset clears all valid flags; no clearing pass.
module atan2_polynomial_angle
(
    input  logic clk,
    input  logic rst_n,
    a2pa_stream_if.sink   in_ch,
    a2pa_stream_if.source out_ch
);
    import a2pa_pkg::*;

    logic                   advance;
    div_cell_t              head_reg;
    div_cell_t              head_next;
    div_cell_t              chain [DIV_CELLS+1];
    logic signed [INPUT_WIDTH-1:0] y;
    logic signed [INPUT_WIDTH-1:0] x;
    logic signed [MAG_WIDTH-1:0]   ya;
    logic signed [MAG_WIDTH-1:0]   num;
    logic signed [MAG_WIDTH-1:0]   den;
    logic [MAG_WIDTH-1:0]          mag;
    logic [DIVD_WIDTH-1:0]         divd_full;
    div_cell_t                     tail;
    logic [QUOT_BITS:0]            quot_r;
    logic signed [T_WIDTH-1:0]     t_val;

    assign advance     = !out_ch.valid || out_ch.ready;
    assign in_ch.ready = advance;

    always_comb
    begin
        y  = in_ch.payload.sine_value;
        x  = in_ch.payload.cosine_value;
        ya = (y[INPUT_WIDTH-1] ? -MAG_WIDTH'(y) : MAG_WIDTH'(y)) + MAG_WIDTH'(1);
        if (!x[INPUT_WIDTH-1])
        begin
            num = MAG_WIDTH'(x) - ya;
            den = MAG_WIDTH'(x) + ya;
        end
        else
        begin
            num = MAG_WIDTH'(x) + ya;
            den = ya - MAG_WIDTH'(x);
        end
        mag = num[MAG_WIDTH-1] ? MAG_WIDTH'(-num) : MAG_WIDTH'(num);
        // dividend = (mag << F) + den/2, the cells shift in its low F+1 bits
        divd_full = (DIVD_WIDTH'(mag) << RATIO_FRAC_BITS)
                    + DIVD_WIDTH'(den[MAG_WIDTH-1:1]);
        head_next         = '0;
        head_next.valid   = in_ch.valid;
        // preload remainder with the dividend bits above the quotient window
        head_next.rem     = REM_WIDTH'(divd_full >> QUOT_BITS);
        head_next.divd    = divd_full << (DIVD_WIDTH - QUOT_BITS);
        head_next.den     = den;
        head_next.num_neg = num[MAG_WIDTH-1];
        head_next.x_neg   = x[INPUT_WIDTH-1];
        head_next.y_neg   = y[INPUT_WIDTH-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
        end
        else if (advance)
        begin
            head_reg <= head_next;
        end
    end

    assign chain[0] = head_reg;

    genvar g;
    generate
        for (g = 0; g < DIV_CELLS; g++)
        begin : g_div
            a2pa_div_cell u_cell
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .advance  (advance),
                .cell_in  (chain[g]),
                .cell_out (chain[g+1])
            );
        end
    endgenerate

    assign tail   = chain[DIV_CELLS];
    assign quot_r = {1'b0, tail.quot};
    assign t_val  = tail.num_neg ? -T_WIDTH'(quot_r) : T_WIDTH'(quot_r);

    a2pa_poly u_poly
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (tail.valid),
        .t_in      (t_val),
        .x_neg     (tail.x_neg),
        .y_neg     (tail.y_neg),
        .out_valid (out_ch.valid),
        .angle     (out_ch.payload.angle)
    );

`ifndef SYNTHESIS
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(tail.valid))
        else $error("pipeline moved during stall");
    a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready == (!out_ch.valid || out_ch.ready))
        else $error("ready mismatch");
    a_den_pos: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg.valid |-> head_reg.den != '0)
        else $error("zero divisor");
`endif

endmodule
